### sv/range_and_threshold_extent_assert.svh
// ---------------------------------------------------------------------------
// range_and_threshold_extent assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in rst.
// ---------------------------------------------------------------------------
`ifndef RANGE_AND_THRESHOLD_EXTENT_ASSERT_SVH
`define RANGE_AND_THRESHOLD_EXTENT_ASSERT_SVH

// same-cycle implication
`define RTE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rte assertion failed");

// next-cycle implication
`define RTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rte assertion failed");

`endif

### sv/rte_pkg.sv
// ---------------------------------------------------------------------------
// rte_pkg
// Types, codes and defaults for the range-AND threshold extent block.
// ---------------------------------------------------------------------------
package rte_pkg;

  localparam int MAX_ELEMENTS_DEF = 4096;
  localparam int TABLE_LEVELS_DEF = 13;
  localparam int VALUE_BITS_DEF   = 30;

  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_BUILD  = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_BELOW = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_B0_RD,
    S_B0_WR,
    S_BL_CHK,
    S_BL_RD2,
    S_BL_WR,
    S_Q_CHK,
    S_Q_MID,
    S_Q_RD2,
    S_Q_CMP
  } state_t;

  // index of highest set bit, 0 for 0 or 1
  function automatic int floor_log2(input logic [31:0] x);
    int r;
    r = 0;
    for (int k = 0; k < 32; k++) begin
      if (x[k]) r = k;
    end
    return r;
  endfunction

endpackage

### sv/rte_ram.sv
// ---------------------------------------------------------------------------
// rte_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module rte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### sv/range_and_threshold_extent.sv
// ---------------------------------------------------------------------------
// range_and_threshold_extent
// Element store, sparse AND table build and threshold extent search.
// ---------------------------------------------------------------------------
// Accepts a transaction when start is high and busy is low. A write never
// raises busy. A build copies each element into table level 0 through the
// element read port, then fills each higher level by reading two entries of
// the level below through the table's single read port and writing their
// AND. A query first checks the start element, then runs binary-search
// probes (two table reads, then AND and compare) until the search ends; a
// start below threshold answers right after the check, and an out-of-range
// start answers in the cycle after accept without raising busy. The result
// shows on status/right_end for one cycle with done high, in the first cycle
// busy is low, and cannot be stalled. The user must write length_in_use
// through cfg_we only while idle; the block itself does not enforce this.
module range_and_threshold_extent #(
  parameter int MAX_ELEMENTS = rte_pkg::MAX_ELEMENTS_DEF,
  parameter int TABLE_LEVELS = rte_pkg::TABLE_LEVELS_DEF,
  parameter int VALUE_BITS   = rte_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] length_in_use,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [11:0] position,
  input  logic [29:0] element_value,
  input  logic [29:0] threshold,
  output logic        done,
  output logic [1:0]  status,
  output logic [11:0] right_end
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CW    = IDX_W + 2;
  localparam int LW    = $clog2(TABLE_LEVELS);
  localparam int TA_W  = LW + IDX_W;
  localparam int TDEPTH = TABLE_LEVELS * (2 ** IDX_W);

  rte_pkg::state_t state, state_next;

  logic [12:0]         length;
  logic [LW-1:0]       lvl, lvl_next;
  logic [CW-1:0]       idx, idx_next;
  logic [CW-1:0]       lo, lo_next, hi, hi_next, mid, mid_next, best, best_next;
  logic [CW-1:0]       qpos, qpos_next;
  logic [VALUE_BITS-1:0] thr, thr_next, acc, acc_next;
  logic                done_next;
  logic [1:0]          status_next;
  logic [11:0]         right_end_next;

  logic [CW-1:0]       n;
  logic [CW-1:0]       mid_calc;
  logic [LW-1:0]       j_calc;
  logic                accept;
  int                  jl;

  // RAM ports
  logic                  e_we;
  logic [IDX_W-1:0]      e_waddr, e_raddr;
  logic [VALUE_BITS-1:0] e_wdata, e_rdata;
  logic                  t_we;
  logic [TA_W-1:0]       t_waddr, t_raddr;
  logic [VALUE_BITS-1:0] t_wdata, t_rdata;

  rte_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ELEMENTS)) u_elem (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  rte_ram #(.WIDTH(VALUE_BITS), .DEPTH(TDEPTH)) u_table (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  assign busy   = (state != rte_pkg::S_IDLE);
  assign accept = start && !busy;
  assign n = (32'(length) > MAX_ELEMENTS) ? CW'(MAX_ELEMENTS) : CW'(length);
  assign mid_calc = lo + ((hi - lo) >> 1);

  always_comb begin
    jl = rte_pkg::floor_log2(32'(mid_calc - qpos + CW'(1)));
    if (jl > TABLE_LEVELS - 1) jl = TABLE_LEVELS - 1;
    j_calc = LW'(jl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rte_pkg::S_IDLE;
      length <= 13'd1;
      done   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (cfg_we) length <= length_in_use;
    end
    lvl       <= lvl_next;
    idx       <= idx_next;
    lo        <= lo_next;
    hi        <= hi_next;
    mid       <= mid_next;
    best      <= best_next;
    qpos      <= qpos_next;
    thr       <= thr_next;
    acc       <= acc_next;
    status    <= status_next;
    right_end <= right_end_next;
  end

  // sequencer and datapath next values
  always_comb begin
    state_next     = state;
    lvl_next       = lvl;
    idx_next       = idx;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    best_next      = best;
    qpos_next      = qpos;
    thr_next       = thr;
    acc_next       = acc;
    done_next      = 1'b0;
    status_next    = status;
    right_end_next = right_end;
    unique case (state)
      rte_pkg::S_IDLE: begin
        if (accept && action == rte_pkg::ACT_BUILD) begin
          idx_next   = '0;
          lvl_next   = '0;
          state_next = rte_pkg::S_B0_RD;
        end else if (accept && action == rte_pkg::ACT_QUERY) begin
          thr_next  = VALUE_BITS'({2'b00, threshold});
          qpos_next = CW'(32'(position));
          if (32'(position) >= 32'(n)) begin
            done_next      = 1'b1;
            status_next    = rte_pkg::ST_RANGE;
            right_end_next = '0;
          end else begin
            state_next = rte_pkg::S_Q_CHK;
          end
        end
      end
      rte_pkg::S_B0_RD: begin
        if (idx < n) begin
          state_next = rte_pkg::S_B0_WR;
        end else begin
          idx_next   = '0;
          lvl_next   = LW'(1);
          state_next = rte_pkg::S_BL_CHK;
        end
      end
      rte_pkg::S_B0_WR: begin
        idx_next   = idx + CW'(1);
        state_next = rte_pkg::S_B0_RD;
      end
      rte_pkg::S_BL_CHK: begin
        if (32'(idx) + (32'd1 << lvl) <= 32'(n)) begin
          state_next = rte_pkg::S_BL_RD2;
        end else if (32'(lvl) == TABLE_LEVELS - 1) begin
          state_next = rte_pkg::S_IDLE;
        end else begin
          idx_next = '0;
          lvl_next = lvl + LW'(1);
        end
      end
      rte_pkg::S_BL_RD2: begin
        acc_next   = t_rdata;
        state_next = rte_pkg::S_BL_WR;
      end
      rte_pkg::S_BL_WR: begin
        idx_next   = idx + CW'(1);
        state_next = rte_pkg::S_BL_CHK;
      end
      rte_pkg::S_Q_CHK: begin
        if (e_rdata < thr) begin
          done_next      = 1'b1;
          status_next    = rte_pkg::ST_BELOW;
          right_end_next = '0;
          state_next     = rte_pkg::S_IDLE;
        end else begin
          lo_next    = qpos;
          hi_next    = n - CW'(1);
          best_next  = qpos;
          state_next = rte_pkg::S_Q_MID;
        end
      end
      rte_pkg::S_Q_MID: begin
        if (lo > hi) begin
          done_next      = 1'b1;
          status_next    = rte_pkg::ST_FOUND;
          right_end_next = 12'(32'(best));
          state_next     = rte_pkg::S_IDLE;
        end else begin
          mid_next   = mid_calc;
          lvl_next   = j_calc;
          state_next = rte_pkg::S_Q_RD2;
        end
      end
      rte_pkg::S_Q_RD2: begin
        acc_next   = t_rdata;
        state_next = rte_pkg::S_Q_CMP;
      end
      rte_pkg::S_Q_CMP: begin
        if ((acc & t_rdata) >= thr) begin
          best_next  = mid;
          lo_next    = mid + CW'(1);
          state_next = rte_pkg::S_Q_MID;
        end else if (mid == '0) begin
          done_next      = 1'b1;
          status_next    = rte_pkg::ST_FOUND;
          right_end_next = 12'(32'(best));
          state_next     = rte_pkg::S_IDLE;
        end else begin
          hi_next    = mid - CW'(1);
          state_next = rte_pkg::S_Q_MID;
        end
      end
      default: state_next = rte_pkg::S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    e_we    = 1'b0;
    e_waddr = IDX_W'(32'(position));
    e_wdata = VALUE_BITS'({2'b00, element_value});
    e_raddr = IDX_W'(32'(position));
    t_we    = 1'b0;
    t_waddr = {lvl, idx[IDX_W-1:0]};
    t_wdata = e_rdata;
    t_raddr = {lvl, idx[IDX_W-1:0]};
    unique case (state)
      rte_pkg::S_IDLE: begin
        e_we = accept && action == rte_pkg::ACT_WRITE && 32'(position) < MAX_ELEMENTS;
      end
      rte_pkg::S_B0_RD: e_raddr = idx[IDX_W-1:0];
      rte_pkg::S_B0_WR: begin
        t_we = 1'b1;
      end
      rte_pkg::S_BL_CHK: t_raddr = {lvl - LW'(1), idx[IDX_W-1:0]};
      rte_pkg::S_BL_RD2: begin
        t_raddr = {lvl - LW'(1), IDX_W'(32'(idx) + (32'd1 << (lvl - LW'(1))))};
      end
      rte_pkg::S_BL_WR: begin
        t_we    = 1'b1;
        t_wdata = acc & t_rdata;
      end
      rte_pkg::S_Q_MID: t_raddr = {j_calc, qpos[IDX_W-1:0]};
      rte_pkg::S_Q_RD2: begin
        t_raddr = {lvl, IDX_W'(32'(mid) + 32'd1 - (32'd1 << lvl))};
      end
      default: ;
    endcase
  end

  `include "range_and_threshold_extent_assert.svh"

  `RTE_ASSERT_NOW(a_zero_end, done && status != rte_pkg::ST_FOUND, right_end == '0)
  `RTE_ASSERT_NOW(a_done_idle, done, !busy)
  `RTE_ASSERT_NEXT(a_query_moves, accept && action == rte_pkg::ACT_QUERY, busy || done)
  `RTE_ASSERT_NEXT(a_write_quiet, accept && action == rte_pkg::ACT_WRITE, !busy && !done)

endmodule
